@@ rtl/thermistor_beta_temperature_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the thermistor beta temperature core
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_BETA_TEMPERATURE_CORE_MACROS_SVH
`define THERMISTOR_BETA_TEMPERATURE_CORE_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define TBT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define TBT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/tbt_pkg.sv @@
// ----------------------------------------------------------------------------
// Thermistor beta temperature package
// Widths, constants and shared types of the thermistor temperature core.
// ----------------------------------------------------------------------------
package tbt_pkg;

    localparam int VOLT_W = 13;
    localparam int RES_W  = 20;
    localparam int BETA_W = 13;
    localparam int LOG_W  = 21;   // 5 integer bits, 16 fraction bits
    localparam int LOG_STAGES = 16;
    localparam int SUM_W  = 24;   // signed sum of four log terms
    localparam int DEN_W  = 50;   // signed denominator in Q32 kelvin
    localparam int UD_W   = 49;   // positive denominator
    localparam int REM_W  = 64;
    localparam int QUO_W  = 16;
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Register indexes of the configuration port
    localparam logic [7:0] CFG_DIV_R  = 8'd0;
    localparam logic [7:0] CFG_BETA   = 8'd1;
    localparam logic [7:0] CFG_NOM_R  = 8'd2;
    localparam logic [7:0] CFG_SUPPLY = 8'd3;

    localparam logic [RES_W-1:0]  RST_DIV_R  = 20'd10000;
    localparam logic [BETA_W-1:0] RST_BETA   = 13'd3950;
    localparam logic [RES_W-1:0]  RST_NOM_R  = 20'd10000;
    localparam logic [VOLT_W-1:0] RST_SUPPLY = 13'd3300;

    // T0 * ln2 in Q16, T0 in centi-kelvin, 0 degC in centi-kelvin
    localparam logic [23:0] T0_LN2_Q16     = 24'd13543790;
    localparam logic [14:0] T0_CENTI_K     = 15'd29815;
    localparam logic [16:0] ZERO_C_CENTI_K = 17'd27315;
    localparam logic [15:0] CK_SAT         = 16'd60082;
    localparam logic [15:0] TEMP_MAX       = 16'h7FFF;

    typedef struct packed {
        logic [RES_W-1:0]  div_r;
        logic [BETA_W-1:0] beta;
        logic [RES_W-1:0]  nom_r;
        logic [VOLT_W-1:0] supply;
    } t_cfg;

    // One classified sample on its way to the back end
    typedef struct packed {
        logic              err;
        logic [VOLT_W-1:0] v;
        logic [VOLT_W-1:0] sv;
        logic [RES_W-1:0]  rd;
        logic [RES_W-1:0]  rn;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ rtl/tbt_front.sv @@
// ----------------------------------------------------------------------------
// Thermistor front end
// Holds the configuration registers, takes samples and classifies them.
// ----------------------------------------------------------------------------
module tbt_front import tbt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_addr,
    input  logic [RES_W-1:0]  i_cfg_data,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [15:0]       i_s_axis_tdata,   // [12:0] sample_mv
    output t_cfg              o_cfg,
    output logic              o_push,
    output t_item             o_item,
    input  t_qstat            i_qstat
);

    t_cfg              r_cfg;
    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [VOLT_W-1:0] v;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_valid || !i_qstat.full;
    assign o_push          = r_valid && !i_qstat.full;
    assign o_cfg           = r_cfg;
    assign o_item          = r_item;

    // Range check and divider terms of the incoming word
    always_comb begin
        v          = i_s_axis_tdata[VOLT_W-1:0];
        n_item.err = (v == '0) || (v >= r_cfg.supply);
        n_item.v   = v;
        n_item.sv  = r_cfg.supply - v;
        n_item.rd  = (r_cfg.div_r == '0) ? RES_W'(1) : r_cfg.div_r;
        n_item.rn  = (r_cfg.nom_r == '0) ? RES_W'(1) : r_cfg.nom_r;
    end

    // Configuration registers and the stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.div_r  <= RST_DIV_R;
            r_cfg.beta   <= RST_BETA;
            r_cfg.nom_r  <= RST_NOM_R;
            r_cfg.supply <= RST_SUPPLY;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    CFG_DIV_R:  r_cfg.div_r  <= i_cfg_data;
                    CFG_BETA:   r_cfg.beta   <= i_cfg_data[BETA_W-1:0];
                    CFG_NOM_R:  r_cfg.nom_r  <= i_cfg_data;
                    CFG_SUPPLY: r_cfg.supply <= i_cfg_data[VOLT_W-1:0];
                    default: ;
                endcase
            end
            if (o_s_axis_tready) begin
                r_valid <= i_s_axis_tvalid;
            end
        end
    end

    // Sample payload
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_item <= n_item;
        end
    end

endmodule

@@ rtl/tbt_queue.sv @@
// ----------------------------------------------------------------------------
// Thermistor item queue
// Short queue that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module tbt_queue import tbt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_qstat
);

    t_item          r_mem [0:QDEPTH-1];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_item        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ rtl/tbt_log2.sv @@
// ----------------------------------------------------------------------------
// Pipelined base-two logarithm
// Q16 log2 of a 20 bit integer: leading one search, then one squaring a stage.
// ----------------------------------------------------------------------------
module tbt_log2 import tbt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [RES_W-1:0] i_x,
    output logic [LOG_W-1:0] o_log
);

    logic [31:0] r_y  [0:LOG_STAGES];
    logic [4:0]  r_ip [0:LOG_STAGES];
    logic [15:0] r_fr [0:LOG_STAGES];
    logic [31:0] n_y  [1:LOG_STAGES];
    logic [15:0] n_fr [1:LOG_STAGES];
    logic [4:0]  msb;
    logic [31:0] xe;
    logic [31:0] y0;

    // Leading one and normalized mantissa in Q31
    always_comb begin
        msb = '0;
        for (int b = 0; b < RES_W; b++) begin
            if (i_x[b]) begin
                msb = 5'(b);
            end
        end
        xe = {{(32-RES_W){1'b0}}, i_x};
        y0 = xe << (5'd31 - msb);
    end

    // Each stage squares the mantissa and yields one fraction bit
    always_comb begin
        logic [63:0] p;
        logic [32:0] t;
        p = '0;
        t = '0;
        for (int k = 0; k < LOG_STAGES; k++) begin
            p = {32'b0, r_y[k]} * {32'b0, r_y[k]};
            t = p[63:31];
            if (t[32]) begin
                n_y[k+1]  = t[32:1];
                n_fr[k+1] = {r_fr[k][14:0], 1'b1};
            end else begin
                n_y[k+1]  = t[31:0];
                n_fr[k+1] = {r_fr[k][14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y[0]  <= y0;
            r_fr[0] <= '0;
            r_ip[0] <= msb;
            for (int k = 1; k <= LOG_STAGES; k++) begin
                r_y[k]  <= n_y[k];
                r_fr[k] <= n_fr[k];
                r_ip[k] <= r_ip[k-1];
            end
        end
    end

    assign o_log = {r_ip[LOG_STAGES], r_fr[LOG_STAGES]};

endmodule

@@ rtl/tbt_back.sv @@
// ----------------------------------------------------------------------------
// Thermistor arithmetic back end
// Logs, beta denominator, rounded restoring division and the output register.
// ----------------------------------------------------------------------------
module tbt_back import tbt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BETA_W-1:0] i_beta,
    input  logic              i_valid,
    input  t_item             i_item,
    output logic              o_en,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [15:0]       o_m_axis_tdata,   // [15:0] temperature_centi_c
    output logic [0:0]        o_m_axis_tuser    // [0] status
);

    logic en;
    logic [LOG_W-1:0] lg_rd, lg_v, lg_sv, lg_rn;

    // Log stage sideband
    logic r_sb_v [0:LOG_STAGES];
    logic r_sb_e [0:LOG_STAGES];

    // Sum, denominator and division set-up stages
    logic                    r_l_v, r_l_e;
    logic signed [SUM_W-1:0] r_l;
    logic                    r_d_v, r_d_e;
    logic signed [DEN_W-1:0] r_d;
    logic signed [48:0]      prod;
    logic signed [DEN_W-1:0] n_d;

    logic [27:0]     bk;
    logic [UD_W-1:0] ud;
    logic [REM_W-1:0] n_rem;
    logic            n_sat;

    // Division stages, one quotient bit each
    logic             r_dv_v   [0:QUO_W];
    logic             r_dv_e   [0:QUO_W];
    logic             r_dv_sat [0:QUO_W];
    logic [REM_W-1:0] r_dv_rem [0:QUO_W];
    logic [UD_W-1:0]  r_dv_ud  [0:QUO_W];
    logic [QUO_W-1:0] r_dv_q   [0:QUO_W];
    logic [REM_W-1:0] n_dv_rem [1:QUO_W];
    logic [QUO_W-1:0] n_dv_q   [1:QUO_W];

    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic        r_out_status;
    logic [16:0] ck_c;
    logic [15:0] n_temp;

    assign en   = !r_out_valid || i_m_axis_tready;
    assign o_en = en;

    tbt_log2 u_log_rd (.i_clk(i_clk), .i_en(en), .i_x(i_item.rd), .o_log(lg_rd));
    tbt_log2 u_log_v  (.i_clk(i_clk), .i_en(en),
                       .i_x({{(RES_W-VOLT_W){1'b0}}, i_item.v}), .o_log(lg_v));
    tbt_log2 u_log_sv (.i_clk(i_clk), .i_en(en),
                       .i_x({{(RES_W-VOLT_W){1'b0}}, i_item.sv}), .o_log(lg_sv));
    tbt_log2 u_log_rn (.i_clk(i_clk), .i_en(en), .i_x(i_item.rn), .o_log(lg_rn));

    // Denominator beta * 2^32 + T0 * ln2 * L
    always_comb begin
        prod = $signed({1'b0, T0_LN2_Q16}) * r_l;
        n_d  = $signed({{(DEN_W-BETA_W-32){1'b0}}, i_beta, 32'b0})
             + $signed({prod[48], prod});
    end

    // Rounded numerator and the quotient overflow check
    always_comb begin
        bk    = {15'b0, i_beta} * {13'b0, T0_CENTI_K};
        ud    = r_d[UD_W-1:0];
        n_rem = {4'b0, bk, 32'b0} + {16'b0, ud[UD_W-1:1]};
        n_sat = r_d[DEN_W-1] || (r_d == '0)
             || ({1'b0, n_rem} >= {ud, 16'b0});
    end

    // Restoring division steps
    always_comb begin
        logic [64:0] trial;
        trial = '0;
        for (int k = 0; k < QUO_W; k++) begin
            trial = {16'b0, r_dv_ud[k]} << (QUO_W - 1 - k);
            n_dv_rem[k+1] = r_dv_rem[k];
            n_dv_q[k+1]   = r_dv_q[k];
            if ({1'b0, r_dv_rem[k]} >= trial) begin
                n_dv_rem[k+1] = r_dv_rem[k] - trial[REM_W-1:0];
                n_dv_q[k+1][QUO_W-1-k] = 1'b1;
            end
        end
    end

    // Centi-kelvin to centi-degrees with saturation
    always_comb begin
        ck_c = {1'b0, r_dv_q[QUO_W]} - ZERO_C_CENTI_K;
        if (r_dv_sat[QUO_W] || (r_dv_q[QUO_W] >= CK_SAT)) begin
            n_temp = TEMP_MAX;
        end else begin
            n_temp = ck_c[15:0];
        end
    end

    // Valid bits through every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LOG_STAGES; k++) begin
                r_sb_v[k] <= 1'b0;
            end
            for (int k = 0; k <= QUO_W; k++) begin
                r_dv_v[k] <= 1'b0;
            end
            r_l_v       <= 1'b0;
            r_d_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sb_v[0] <= i_valid;
            for (int k = 1; k <= LOG_STAGES; k++) begin
                r_sb_v[k] <= r_sb_v[k-1];
            end
            r_l_v     <= r_sb_v[LOG_STAGES];
            r_d_v     <= r_l_v;
            r_dv_v[0] <= r_d_v;
            for (int k = 1; k <= QUO_W; k++) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
            r_out_valid <= r_dv_v[QUO_W];
        end
    end

    // Payload through every stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb_e[0] <= i_item.err;
            for (int k = 1; k <= LOG_STAGES; k++) begin
                r_sb_e[k] <= r_sb_e[k-1];
            end
            r_l_e <= r_sb_e[LOG_STAGES];
            r_l   <= $signed({3'b0, lg_rd}) + $signed({3'b0, lg_v})
                   - $signed({3'b0, lg_sv}) - $signed({3'b0, lg_rn});
            r_d_e <= r_l_e;
            r_d   <= n_d;
            r_dv_e[0]   <= r_d_e;
            r_dv_sat[0] <= n_sat;
            r_dv_rem[0] <= n_rem;
            r_dv_ud[0]  <= ud;
            r_dv_q[0]   <= '0;
            for (int k = 1; k <= QUO_W; k++) begin
                r_dv_e[k]   <= r_dv_e[k-1];
                r_dv_sat[k] <= r_dv_sat[k-1];
                r_dv_rem[k] <= n_dv_rem[k];
                r_dv_ud[k]  <= r_dv_ud[k-1];
                r_dv_q[k]   <= n_dv_q[k];
            end
            r_out_status <= r_dv_e[QUO_W];
            r_out_data   <= r_dv_e[QUO_W] ? 16'd0 : n_temp;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_status;

endmodule

@@ rtl/thermistor_beta_temperature_core.sv @@
// ----------------------------------------------------------------------------
// Thermistor beta temperature core
// Divider voltage in millivolts to temperature in hundredths of a degree C.
// ----------------------------------------------------------------------------
//  channel   direction  signals                       content
//  s_axis    in         tvalid tready tdata[15:0]     sample_mv in [12:0]
//  m_axis    out        tvalid tready tdata tuser     temperature, status
//  cfg       in         valid ready addr[7:0] data    register writes
//
// One word is taken per cycle while the queue has room; a word passes
// through the front register, queue, 17 log stages, 3 arithmetic stages, 16
// division stages and the output register.
// Reset clears the registers to their defaults and empties every stage.
// A stalled output freezes the back end; the queue lets the front keep
// taking words until it fills.
// ----------------------------------------------------------------------------
`include "thermistor_beta_temperature_core_macros.svh"

module thermistor_beta_temperature_core import tbt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_addr,
    input  logic [RES_W-1:0]  i_cfg_data,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [15:0]       i_s_axis_tdata,   // [12:0] sample_mv
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [15:0]       o_m_axis_tdata,   // [15:0] temperature_centi_c
    output logic [0:0]        o_m_axis_tuser    // [0] status
);

    t_cfg   cfg;
    logic   push;
    logic   pop;
    logic   back_en;
    t_item  front_item;
    t_item  head_item;
    t_qstat qstat;

    tbt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_cfg           (cfg),
        .o_push          (push),
        .o_item          (front_item),
        .i_qstat         (qstat)
    );

    tbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_qstat (qstat)
    );

    // The back end pulls a word whenever its pipeline moves and the queue holds one
    assign pop = back_en && !qstat.empty;

    tbt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_beta          (cfg.beta),
        .i_valid         (pop),
        .i_item          (head_item),
        .o_en            (back_en),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Queue never overflows or underflows
    `TBT_ASSERT_IMPLY(a_no_overflow, push, !qstat.full || pop, "queue overflow")
    `TBT_ASSERT_IMPLY(a_no_underflow, pop, !qstat.empty, "queue underflow")
    // Error words carry a zero temperature
    `TBT_ASSERT_IMPLY(a_err_zero, o_m_axis_tvalid && o_m_axis_tuser[0],
        o_m_axis_tdata == 16'd0, "error word with nonzero temperature")
    // Valid readings never fall below absolute zero
    `TBT_ASSERT_IMPLY(a_temp_floor, o_m_axis_tvalid && !o_m_axis_tuser[0],
        $signed(o_m_axis_tdata) >= -16'sd27315, "temperature below absolute zero")

endmodule
